[rtl/core/msrd_pkg.sv]
// shared types and constants for the minimal standard random draws block
// no dependencies; imported by every module under rtl/core
package msrd_pkg;

  // request kinds
  localparam logic [1:0] FUNC_UNIFORM = 2'd0;
  localparam logic [1:0] FUNC_BOUNDED = 2'd1;
  localparam logic [1:0] FUNC_BITS    = 2'd2;

  // generator constants
  localparam logic [14:0] MULTIPLIER = 15'd16807;
  localparam logic [31:0] MODULUS    = 32'h7FFF_FFFF;
  localparam logic [30:0] SEED_RESET = 31'd1;

  // configuration register map
  localparam logic SEED_REG = 1'b0;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] bound;
    logic [4:0]  bit_count;
  } req_t;

  typedef struct packed {
    logic [31:0] draw_value;
    logic [30:0] state_now;
  } rsp_t;

  // one classified request waiting for the back end
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] bound;
    logic [4:0]  bit_count;
    logic [30:0] state;
  } job_t;

  typedef struct packed {
    logic        load;
    logic [30:0] value;
  } seed_load_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

[rtl/core/msrd_front.sv]
// front end: generator state, one minimal standard step per accepted request
// depends on msrd_pkg
module msrd_front import msrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  seed_load_t seed,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  input  logic       q_full,
  output logic       push,
  output job_t       job,
  output logic [30:0] gen_state
);

  logic [30:0] state;
  logic [30:0] state_next;
  logic [45:0] prod;
  logic [31:0] folded;

  // state * 16807 folded mod 2^31-1
  always_comb begin
    prod   = 46'(state) * 46'(MULTIPLIER);
    folded = {1'b0, prod[30:0]} + 32'(prod[45:31]);
    if (folded >= MODULUS) begin
      folded = folded - MODULUS;
    end
    state_next = folded[30:0];
  end

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;
  assign gen_state = state;

  always_comb begin
    job.func      = req.func;
    job.bound     = req.bound;
    job.bit_count = req.bit_count;
    job.state     = state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEED_RESET;
    end else if (seed.load) begin
      state <= seed.value;
    end else if (push) begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/msrd_queue.sv]
// small fifo between front and back ends
// depends on msrd_pkg
module msrd_queue import msrd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  job_t        din,
  output logic        out_valid,
  input  logic        out_stall,
  output job_t        dout,
  output queue_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));
  assign out_valid  = !stat.empty;
  assign pop        = out_valid && !out_stall;
  assign dout       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/msrd_back.sv]
// back end: bound scaling multiply stage, then result select into output register
// depends on msrd_pkg
module msrd_back import msrd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_stall,
  input  job_t job,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic        a_valid;
  logic [1:0]  a_func;
  logic [4:0]  a_nbits;
  logic [30:0] a_state;
  logic [62:0] a_prod;
  logic        a_load;
  logic        o_load;
  logic [4:0]  shamt;
  logic [31:0] draw;

  assign o_load  = !rsp_valid || !rsp_stall;
  assign a_load  = !a_valid || o_load;
  assign q_stall = !a_load;

  always_comb begin
    shamt = 5'd31 - a_nbits;
    case (a_func)
      FUNC_UNIFORM: draw = {1'b0, a_state};
      FUNC_BOUNDED: draw = a_prod[62:31];
      FUNC_BITS:    draw = {1'b0, a_state} >> shamt;
      default:      draw = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_load && q_valid) begin
      a_func  <= job.func;
      a_nbits <= job.bit_count;
      a_state <= job.state;
      a_prod  <= 63'(job.bound) * 63'(job.state);
    end
    if (o_load && a_valid) begin
      rsp.draw_value <= draw;
      rsp.state_now  <= a_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= q_valid;
      end
      if (o_load) begin
        rsp_valid <= a_valid;
      end
    end
  end

endmodule

[rtl/core/minimal_standard_random_draws_top.sv]
// top level of the minimal standard random draws block
// depends on msrd_pkg, msrd_front, msrd_queue, msrd_back
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_t  {func, bound, bit_count}
//   rsp      out        rsp_valid/rsp_stall  rsp_t  {draw_value, state_now}
//   apb      in/out     psel/penable/pready  start_seed at byte address 0
//
// one request per cycle sustained while rsp_stall stays low; the generator step
// (31x15 multiply plus mersenne fold) in the front end sets that figure
// a result passes through the queue, the scaling stage and the output register
// reset is synchronous: generator state and seed return to 1, queue and pipe empty
// rsp_stall holds the output register; the queue then fills and raises req_stall
module minimal_standard_random_draws_top import msrd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [30:0] start_seed;
  seed_load_t  seed;
  logic        cfg_wr;

  logic        push;
  job_t        job_in;
  job_t        job_out;
  logic        q_valid;
  logic        q_stall;
  queue_stat_t q_stat;
  logic [30:0] gen_state;

  // config register, always-ready access
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign seed.load  = cfg_wr && (paddr[2] == SEED_REG);
  assign seed.value = pwdata[30:0];
  assign prdata     = (paddr[2] == SEED_REG) ? {1'b0, start_seed} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_seed <= SEED_RESET;
    end else if (seed.load) begin
      start_seed <= seed.value;
    end
  end

  // front end advances the generator and classifies the request
  msrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_stat.full),
    .push      (push),
    .job       (job_in),
    .gen_state (gen_state)
  );

  // decouples the generator from the scaling pipe
  msrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (job_in),
    .out_valid (q_valid),
    .out_stall (q_stall),
    .dout      (job_out),
    .stat      (q_stat)
  );

  // back end scales the state into the result
  msrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_stall   (q_stall),
    .job       (job_out),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // a seed write lands in the generator state
  a_seed_load: assert property (@(posedge clk) disable iff (rst)
    seed.load |=> gen_state == $past(pwdata[30:0]))
    else $error("seed write not loaded into generator state");

  // a live state always moves to another nonzero state below the modulus
  a_state_step: assert property (@(posedge clk) disable iff (rst)
    (push && !seed.load && gen_state != '0 && {1'b0, gen_state} != MODULUS)
      |=> (gen_state != $past(gen_state) && gen_state != '0
           && {1'b0, gen_state} != MODULUS))
    else $error("generator step left the valid state range");

  // queue status flags are exclusive
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reported full and empty together");

  // request stall follows the queue fill
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall == q_stat.full)
    else $error("request stall out of step with queue fill");

endmodule

[test/testbench.sv]
// self-checking testbench for minimal_standard_random_draws_top
// drives random and directed draws and seed writes, predicts each result in place
// depends on msrd_pkg and the rtl under rtl/core
`timescale 1ns / 1ps

module testbench;
  import msrd_pkg::*;

  // request kind that the block does not define, still advances the generator
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // byte address of the seed register on the configuration port
  localparam logic [2:0] SEED_ADDR = 3'({SEED_REG, 2'b00});
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 8;
  // cycles let pass after the last result before a seed write
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES = 20;
  // cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 4;
  localparam int RANDOM_PER_PHASE = 134;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  minimal_standard_random_draws_top DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // requests waiting for the driver, results waiting for the checker
  req_t pending_requests[$];
  rsp_t expected_draws[$];

  // own copy of the seed register and the generator
  logic [30:0] seed_value = SEED_RESET;
  logic [30:0] lcg_state = SEED_RESET;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  logic req_fired = 1'b0;
  rsp_t oldest_draw;

  int send_idle_by_phase[PHASES] = '{0, 63, 0, 19};
  int recv_stall_by_phase[PHASES] = '{0, 0, 63, 19};

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // one minimal standard step: s * 16807 mod (2^31 - 1) with a mersenne fold
  function automatic logic [30:0] lcg_advance(input logic [30:0] s);
    logic [63:0] prod;
    logic [63:0] folded;
    prod = 64'(s) * 64'(MULTIPLIER);
    folded = (prod & 64'(MODULUS)) + (prod >> 31);
    if (folded >= 64'(MODULUS)) begin
      folded = folded - 64'(MODULUS);
    end
    return folded[30:0];
  endfunction

  // advances the generator and works out the one result of a request
  function automatic rsp_t predict_draw(input req_t r);
    rsp_t res;
    logic [63:0] scaled;
    lcg_state = lcg_advance(lcg_state);
    scaled = 64'(r.bound) * 64'(lcg_state);
    case (r.func)
      FUNC_UNIFORM: begin
        res.draw_value = {1'b0, lcg_state};
      end
      FUNC_BOUNDED: begin
        res.draw_value = scaled[62:31];
      end
      FUNC_BITS: begin
        res.draw_value = {1'b0, lcg_state} >> (5'd31 - r.bit_count);
      end
      default: begin
        res.draw_value = '0;
      end
    endcase
    res.state_now = lcg_state;
    return res;
  endfunction

  function automatic bit all_quiet();
    return pending_requests.size() == 0 && !req_valid && expected_draws.size() == 0;
  endfunction

  task automatic wait_quiet();
    while (!all_quiet()) @(posedge clk);
  endtask

  task automatic push_request(input logic [1:0] func, input logic [31:0] bound,
                              input logic [4:0] bit_count);
    req_t r;
    r.func = func;
    r.bound = bound;
    r.bit_count = bit_count;
    pending_requests.push_back(r);
  endtask

  // seed write over the apb port, only once the block has gone idle,
  // followed by a read back of the register
  task automatic write_seed(input logic [31:0] value);
    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // setup then access phase of the write
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SEED_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // a write reloads the generator at once
    seed_value = value[30:0];
    lcg_state = value[30:0];
    // read back
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {1'b0, seed_value}) begin
      report_mismatch($sformatf("seed read back %h, want %h", prdata, {1'b0, seed_value}));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // random requests: mostly defined kinds, bounds weighted toward the edges
  task automatic queue_random_requests(input int count);
    logic [1:0] func;
    logic [31:0] bound;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        func = FUNC_UNUSED;
      end else begin
        func = 2'($urandom_range(2));
      end
      case ($urandom_range(7))
        0: bound = '0;
        1: bound = 32'hFFFF_FFFF;
        2: bound = 32'd1;
        3: bound = 32'($urandom_range(1, 255));
        default: bound = $urandom();
      endcase
      push_request(func, bound, 5'($urandom_range(31)));
    end
  endtask

  // driver: a new transaction only once the previous one was taken,
  // so a stalled payload never changes
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fired) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req <= pending_requests.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver stall, redrawn every cycle
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: predicts on each request transaction, checks each result transaction
  always @(posedge clk) begin
    if (rst) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        if (expected_draws.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: draw %h state %h",
                                    rsp.draw_value, rsp.state_now));
        end else begin
          oldest_draw = expected_draws.pop_front();
          if (rsp.draw_value !== oldest_draw.draw_value) begin
            report_mismatch($sformatf("draw_value %h, want %h",
                                      rsp.draw_value, oldest_draw.draw_value));
          end
          if (rsp.state_now !== oldest_draw.state_now) begin
            report_mismatch($sformatf("state_now %h, want %h",
                                      rsp.state_now, oldest_draw.state_now));
          end
        end
      end
      if (req_valid && !req_stall) begin
        expected_draws.push_back(predict_draw(req));
      end
    end
  end

  // watchdog: any transaction on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // single synchronous reset at the start
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed: draws from the reset seed, every kind and its edges
    push_request(FUNC_UNIFORM, 32'd0, 5'd0);
    push_request(FUNC_BOUNDED, 32'hFFFF_FFFF, 5'd0);
    push_request(FUNC_BOUNDED, 32'd1, 5'd31);
    // zero bound gives a zero draw
    push_request(FUNC_BOUNDED, 32'd0, 5'd31);
    push_request(FUNC_BOUNDED, 32'h8000_0000, 5'd1);
    push_request(FUNC_BITS, 32'hFFFF_FFFF, 5'd31);
    push_request(FUNC_BITS, 32'd0, 5'd1);
    // zero bit count shifts the whole state away
    push_request(FUNC_BITS, 32'hFFFF_FFFF, 5'd0);
    // unused kind still steps the generator
    push_request(FUNC_UNUSED, 32'hFFFF_FFFF, 5'd31);

    // largest legal seed
    write_seed(32'd2147483646);
    push_request(FUNC_UNIFORM, 32'd0, 5'd0);
    push_request(FUNC_BOUNDED, 32'hFFFF_FFFF, 5'd16);
    push_request(FUNC_BITS, 32'd7, 5'd31);

    // degenerate seed of zero: the generator sticks at zero
    write_seed(32'd0);
    push_request(FUNC_UNIFORM, 32'hFFFF_FFFF, 5'd31);
    push_request(FUNC_BOUNDED, 32'hFFFF_FFFF, 5'd31);
    push_request(FUNC_BITS, 32'hFFFF_FFFF, 5'd31);

    // all ones on the bus: masked to the modulus, degenerate as well
    write_seed(32'hFFFF_FFFF);
    push_request(FUNC_UNIFORM, 32'd5, 5'd3);
    push_request(FUNC_BITS, 32'd5, 5'd31);

    // smallest seed again
    write_seed(32'd1);
    push_request(FUNC_BOUNDED, 32'd1000, 5'd8);
    push_request(FUNC_BITS, 32'd1000, 5'd16);

    // random phases with different idling, a fresh seed for each,
    // and the sender holding off mid phase until every result is in
    for (int p = 0; p < PHASES; p++) begin
      write_seed(32'($urandom_range(1, 2147483646)));
      send_idle_pct = send_idle_by_phase[p];
      recv_stall_pct = recv_stall_by_phase[p];
      queue_random_requests(RANDOM_PER_PHASE / 2);
      wait_quiet();
      queue_random_requests(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
    end

    wait_quiet();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/msrd_pkg.sv
rtl/core/msrd_front.sv
rtl/core/msrd_queue.sv
rtl/core/msrd_back.sv
rtl/core/minimal_standard_random_draws_top.sv
test/testbench.sv
